FILE: rtl/core/hddr_pkg.sv
// Shared types, constants and clamp helpers for the height difference dirty rectangle block.
package hddr_pkg;

	localparam int CW = 11;
	localparam int EPS_W = 16;
	localparam int IDX_W = 3;

	// Saturation limit for the cell counts
	localparam logic [CW-1:0] MAX_CELLS = 11'd1024;

	localparam logic [CW-1:0] COORD_MAX = {CW{1'b1}};

	// Configuration register indexes
	localparam logic [IDX_W-1:0] IDX_REGION_MIN_X   = 3'd0;
	localparam logic [IDX_W-1:0] IDX_REGION_MIN_Z   = 3'd1;
	localparam logic [IDX_W-1:0] IDX_REGION_MAX_X   = 3'd2;
	localparam logic [IDX_W-1:0] IDX_REGION_MAX_Z   = 3'd3;
	localparam logic [IDX_W-1:0] IDX_CELLS_ACROSS   = 3'd4;
	localparam logic [IDX_W-1:0] IDX_CELLS_DOWN     = 3'd5;
	localparam logic [IDX_W-1:0] IDX_HEIGHT_EPSILON = 3'd6;

	typedef struct packed {
		logic [CW-1:0]    region_min_x;
		logic [CW-1:0]    region_min_z;
		logic [CW-1:0]    region_max_x;
		logic [CW-1:0]    region_max_z;
		logic [CW-1:0]    cells_across;
		logic [CW-1:0]    cells_down;
		logic [EPS_W-1:0] height_epsilon;
	} cfg_t;

	// Result fields apart from the height word
	typedef struct packed {
		logic          write_flag;
		logic [CW-1:0] write_col;
		logic [CW-1:0] write_row;
		logic          pass_done;
		logic          any_changed;
		logic [CW-1:0] rect_left;
		logic [CW-1:0] rect_top;
		logic [CW-1:0] rect_right;
		logic [CW-1:0] rect_bottom;
	} res_t;

	// Widen downwards by one and clamp to 0..lim
	function automatic logic [CW-1:0] clamp_lo(logic [CW-1:0] v, logic [CW-1:0] lim);
		logic [CW-1:0] dec;
		dec = v - 1'b1;
		if (v == '0)
			return '0;
		else if (dec > lim)
			return lim;
		else
			return dec;
	endfunction

	// Widen upwards by one and clamp to 0..lim
	function automatic logic [CW-1:0] clamp_hi(logic [CW-1:0] v, logic [CW-1:0] lim);
		logic [CW:0] inc;
		inc = {1'b0, v} + 1'b1;
		if (inc > {1'b0, lim})
			return lim;
		else
			return inc[CW-1:0];
	endfunction

endpackage

FILE: rtl/core/height_diff_dirty_rect.sv
// Top level of the height difference dirty rectangle block: input and result registers.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------------
//  in      | in_valid / in_stall    | vertex_col, vertex_row, live_height,
//          |                        | saved_height, final_vertex
//  out     | out_valid / out_stall  | write_flag, write_col, write_row, write_height,
//          |                        | pass_done, any_changed, rect_left/top/right/bottom
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One vertex a cycle while in_stall is low; each result passes through the input register and
// then the result register, with the compare and box update between.
// Reset restores the register defaults and an empty box at once; no clearing pass.
// A stalled result holds in its register while the input register takes one more vertex;
// in_stall rises only when both are full and out_stall is high.
module height_diff_dirty_rect
	import hddr_pkg::*;
#(
	parameter int HEIGHT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [CW-1:0]                 vertex_col,
	input  logic [CW-1:0]                 vertex_row,
	input  logic signed [HEIGHT_BITS-1:0] live_height,
	input  logic signed [HEIGHT_BITS-1:0] saved_height,
	input  logic                          final_vertex,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          write_flag,
	output logic [CW-1:0]                 write_col,
	output logic [CW-1:0]                 write_row,
	output logic signed [HEIGHT_BITS-1:0] write_height,
	output logic                          pass_done,
	output logic                          any_changed,
	output logic [CW-1:0]                 rect_left,
	output logic [CW-1:0]                 rect_top,
	output logic [CW-1:0]                 rect_right,
	output logic [CW-1:0]                 rect_bottom,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [IDX_W-1:0]              cfg_index,
	input  logic [EPS_W-1:0]              cfg_data
);

	cfg_t cfg;

	logic                          valid_s1;
	logic [CW-1:0]                 col_s1, row_s1;
	logic signed [HEIGHT_BITS-1:0] live_s1, saved_s1;
	logic                          last_s1;

	logic                   valid_s2;
	res_t                   res_s2;
	logic [HEIGHT_BITS-1:0] height_s2;

	res_t                   res;
	logic [HEIGHT_BITS-1:0] wr_height;
	logic                   advance, load_s1;

	assign cfg_ready = 1'b1;

	hddr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance when the result register is empty or its transfer completes
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			col_s1   <= vertex_col;
			row_s1   <= vertex_row;
			live_s1  <= live_height;
			saved_s1 <= saved_height;
			last_s1  <= final_vertex;
		end
		if (advance && valid_s1) begin
			res_s2    <= res;
			height_s2 <= wr_height;
		end
	end

	hddr_track #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance && valid_s1),
		.cfg       (cfg),
		.col       (col_s1),
		.row       (row_s1),
		.live      (live_s1),
		.saved     (saved_s1),
		.last      (last_s1),
		.res       (res),
		.wr_height (wr_height)
	);

	assign out_valid    = valid_s2;
	assign write_flag   = res_s2.write_flag;
	assign write_col    = res_s2.write_col;
	assign write_row    = res_s2.write_row;
	assign write_height = $signed(height_s2);
	assign pass_done    = res_s2.pass_done;
	assign any_changed  = res_s2.any_changed;
	assign rect_left    = res_s2.rect_left;
	assign rect_top     = res_s2.rect_top;
	assign rect_right   = res_s2.rect_right;
	assign rect_bottom  = res_s2.rect_bottom;

endmodule

FILE: rtl/core/hddr_cfg.sv
// Configuration register file for the height difference dirty rectangle block.
module hddr_cfg
	import hddr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [EPS_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_min_x   <= 11'd0;
			cfg_q.region_min_z   <= 11'd0;
			cfg_q.region_max_x   <= 11'd1024;
			cfg_q.region_max_z   <= 11'd1024;
			cfg_q.cells_across   <= 11'd256;
			cfg_q.cells_down     <= 11'd256;
			cfg_q.height_epsilon <= 16'd66;
		end else if (cfg_valid) begin
			case (cfg_index)
				IDX_REGION_MIN_X:   cfg_q.region_min_x   <= cfg_data[CW-1:0];
				IDX_REGION_MIN_Z:   cfg_q.region_min_z   <= cfg_data[CW-1:0];
				IDX_REGION_MAX_X:   cfg_q.region_max_x   <= cfg_data[CW-1:0];
				IDX_REGION_MAX_Z:   cfg_q.region_max_z   <= cfg_data[CW-1:0];
				IDX_CELLS_ACROSS:   cfg_q.cells_across   <= cfg_data[CW-1:0];
				IDX_CELLS_DOWN:     cfg_q.cells_down     <= cfg_data[CW-1:0];
				IDX_HEIGHT_EPSILON: cfg_q.height_epsilon <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/hddr_track.sv
// Height compare, region test and bounding box tracking for one vertex a cycle while en is high.
module hddr_track
	import hddr_pkg::*;
#(
	parameter int HEIGHT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  cfg_t                          cfg,
	input  logic [CW-1:0]                 col,
	input  logic [CW-1:0]                 row,
	input  logic signed [HEIGHT_BITS-1:0] live,
	input  logic signed [HEIGHT_BITS-1:0] saved,
	input  logic                          last,
	output res_t                          res,
	output logic [HEIGHT_BITS-1:0]        wr_height
);

	logic          seen_q;
	logic [CW-1:0] min_col_q, min_row_q, max_col_q, max_row_q;

	logic [CW-1:0] cx, cz, hx, hz;
	logic signed [HEIGHT_BITS:0] diff;
	logic [HEIGHT_BITS:0] mag;
	logic in_region, wr;
	logic          seen_n;
	logic [CW-1:0] min_col_n, min_row_n, max_col_n, max_row_n;

	always_comb begin
		cx = (cfg.cells_across > MAX_CELLS) ? MAX_CELLS : cfg.cells_across;
		cz = (cfg.cells_down > MAX_CELLS) ? MAX_CELLS : cfg.cells_down;
		hx = (cfg.region_max_x < cx) ? cfg.region_max_x : cx;
		hz = (cfg.region_max_z < cz) ? cfg.region_max_z : cz;

		// One bit of headroom keeps the difference exact
		diff = {live[HEIGHT_BITS-1], live} - {saved[HEIGHT_BITS-1], saved};
		mag  = diff[HEIGHT_BITS] ? $unsigned(-diff) : $unsigned(diff);

		in_region = (col >= cfg.region_min_x) && (col <= hx) &&
		            (row >= cfg.region_min_z) && (row <= hz);
		wr = in_region && (mag > {{(HEIGHT_BITS + 1 - EPS_W){1'b0}}, cfg.height_epsilon});

		seen_n    = seen_q | wr;
		min_col_n = (wr && col < min_col_q) ? col : min_col_q;
		min_row_n = (wr && row < min_row_q) ? row : min_row_q;
		max_col_n = (wr && col > max_col_q) ? col : max_col_q;
		max_row_n = (wr && row > max_row_q) ? row : max_row_q;

		res.write_flag  = wr;
		res.write_col   = wr ? col : '0;
		res.write_row   = wr ? row : '0;
		res.pass_done   = last;
		res.any_changed = last & seen_n;
		if (last && seen_n) begin
			res.rect_left   = clamp_lo(min_col_n, cx);
			res.rect_top    = clamp_lo(min_row_n, cz);
			res.rect_right  = clamp_hi(max_col_n, cx);
			res.rect_bottom = clamp_hi(max_row_n, cz);
		end else begin
			res.rect_left   = '0;
			res.rect_top    = '0;
			res.rect_right  = '0;
			res.rect_bottom = '0;
		end
		wr_height = wr ? $unsigned(saved) : '0;
	end

	// Clear the box after the final vertex of a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			min_col_q <= COORD_MAX;
			min_row_q <= COORD_MAX;
			max_col_q <= '0;
			max_row_q <= '0;
		end else if (en) begin
			if (last) begin
				seen_q    <= 1'b0;
				min_col_q <= COORD_MAX;
				min_row_q <= COORD_MAX;
				max_col_q <= '0;
				max_row_q <= '0;
			end else begin
				seen_q    <= seen_n;
				min_col_q <= min_col_n;
				min_row_q <= min_row_n;
				max_col_q <= max_col_n;
				max_row_q <= max_row_n;
			end
		end
	end

endmodule

FILE: rtl/core/hddr_chk.sv
// Port level checker for the height difference dirty rectangle block, with its bind.
module hddr_chk
	import hddr_pkg::*;
#(
	parameter int HEIGHT_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic                   write_flag,
	input logic [CW-1:0]          write_col,
	input logic [CW-1:0]          write_row,
	input logic [HEIGHT_BITS-1:0] write_height,
	input logic                   pass_done,
	input logic                   any_changed,
	input logic [CW-1:0]          rect_left,
	input logic [CW-1:0]          rect_right
);

	// Input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// Every transfer in is followed by a valid result at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##2 out_valid)
		else $error("result missing two cycles after transfer in");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_flag) |->
			(write_col == '0 && write_row == '0 && write_height == '0))
		else $error("write fields set on a result with no write");

	a_rect_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && any_changed) |-> (pass_done && rect_left <= rect_right))
		else $error("dirty rectangle malformed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(write_col) && $stable(pass_done)))
		else $error("stalled result changed");

endmodule

bind height_diff_dirty_rect hddr_chk #(
	.HEIGHT_BITS (HEIGHT_BITS)
) u_hddr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.write_flag   (write_flag),
	.write_col    (write_col),
	.write_row    (write_row),
	.write_height (write_height),
	.pass_done    (pass_done),
	.any_changed  (any_changed),
	.rect_left    (rect_left),
	.rect_right   (rect_right)
);
